FILE: src/blsu_pkg.sv
// Shared types, constants and codes of the line stamper.
`timescale 1ns / 1ps
`default_nettype none

package blsu_pkg;

    // Coordinate width of stored positions and stamp origins
    localparam int COORD_W   = 16;
    // Width of the endpoint fields and of the spans
    localparam int IN_W      = 15;
    localparam int ERR_W     = 17;
    localparam int SIDE_W    = 7;
    localparam int COLOR_W   = 16;
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(1);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(64);
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(1);

    // Item function codes
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    // Line state loaded on start and advanced on each step
    typedef struct packed {
        logic                       swapped;
        logic signed [COORD_W-1:0]  major_pos;
        logic signed [COORD_W-1:0]  major_end;
        logic signed [COORD_W-1:0]  minor_pos;
        logic        [IN_W-1:0]     major_span;
        logic        [IN_W-1:0]     minor_span;
        logic signed [ERR_W-1:0]    err;
        logic                       minor_down;
        logic        [COLOR_W-1:0]  color;
    } t_line;

    // One stamp word on the result side
    typedef struct packed {
        logic signed [COORD_W-1:0]  rect_x;
        logic signed [COORD_W-1:0]  rect_y;
        logic        [SIDE_W-1:0]   side;
        logic        [COLOR_W-1:0]  color;
        logic                       last;
    } t_stamp;

endpackage

`default_nettype wire

FILE: src/bresenham_line_stamper_unit.sv
// Top level of the line stamper: line state, stamp side register and result register.
// A step word is registered and appears on the result side in the cycle after it is accepted.
// Throughput: one word per cycle unless stalled; a start or an idle step gives no result.
// The figure is set by the single setup/step pass between line state and result register.
// Reset (synchronous, active low): line idle, result register empty, stamp side 1.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_stamper_unit
    import blsu_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write channel
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [SIDE_W-1:0]         i_cfg_data,
    // input channel
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_func,
    input  wire logic signed [IN_W-1:0]    i_start_x,
    input  wire logic signed [IN_W-1:0]    i_start_y,
    input  wire logic signed [IN_W-1:0]    i_end_x,
    input  wire logic signed [IN_W-1:0]    i_end_y,
    input  wire logic [COLOR_W-1:0]        i_pen_color,
    // result channel
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [COORD_W-1:0]      o_rect_x,
    output logic signed [COORD_W-1:0]      o_rect_y,
    output logic [SIDE_W-1:0]              o_rect_side,
    output logic [COLOR_W-1:0]             o_stamp_color,
    output logic                           o_is_last
);

    logic               r_busy, n_busy;
    logic               r_out_valid, n_out_valid;
    logic [SIDE_W-1:0]  r_thickness, n_thickness;
    t_line              r_line, n_line;
    t_stamp             r_out, n_out;
    t_line              setup_line, step_line;
    t_stamp             step_stamp;
    logic               in_fire, step_hit;

    blsu_setup u_setup (
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_pen_color (i_pen_color),
        .o_line      (setup_line)
    );

    blsu_stepper u_stepper (
        .i_line      (r_line),
        .i_thickness (r_thickness),
        .o_stamp     (step_stamp),
        .o_next      (step_line)
    );

    // Accept a word whenever the result register is free or draining
    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign in_fire     = i_valid && o_ready;
    assign step_hit    = in_fire && (i_func == FUNC_STEP) && r_busy;

    // Next state
    always_comb begin
        n_busy      = r_busy;
        n_line      = r_line;
        n_out       = r_out;
        n_thickness = r_thickness;
        n_out_valid = r_out_valid && !i_ready;
        if (i_cfg_valid) begin
            n_thickness = i_cfg_data;
        end
        if (in_fire && (i_func == FUNC_START)) begin
            n_line = setup_line;
            n_busy = 1'b1;
        end else if (step_hit) begin
            n_line      = step_line;
            n_busy      = !step_stamp.last;
            n_out       = step_stamp;
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_thickness <= SIDE_RESET;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_thickness <= n_thickness;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_line <= n_line;
        r_out  <= n_out;
    end

    assign o_valid       = r_out_valid;
    assign o_rect_x      = r_out.rect_x;
    assign o_rect_y      = r_out.rect_y;
    assign o_rect_side   = r_out.side;
    assign o_stamp_color = r_out.color;
    assign o_is_last     = r_out.last;

endmodule

`default_nettype wire

FILE: src/blsu_setup.sv
// Line setup: steepness test, axis swap, endpoint ordering and initial error.
`timescale 1ns / 1ps
`default_nettype none

module blsu_setup
    import blsu_pkg::*;
(
    input  wire logic signed [IN_W-1:0]    i_start_x,
    input  wire logic signed [IN_W-1:0]    i_start_y,
    input  wire logic signed [IN_W-1:0]    i_end_x,
    input  wire logic signed [IN_W-1:0]    i_end_y,
    input  wire logic        [COLOR_W-1:0] i_pen_color,
    output t_line                          o_line
);

    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic signed [COORD_W-1:0] dx, dy, abs_dx, abs_dy;
    logic signed [COORD_W-1:0] sa_maj, sa_min, sb_maj, sb_min;
    logic signed [COORD_W-1:0] lo_maj, lo_min, hi_maj, hi_min;
    logic signed [COORD_W-1:0] span, dmin, abs_dmin;
    logic                      steep;

    // Widen the endpoints
    assign ax = COORD_W'(i_start_x);
    assign ay = COORD_W'(i_start_y);
    assign bx = COORD_W'(i_end_x);
    assign by = COORD_W'(i_end_y);

    // Steep when the y extent beats the x extent
    assign dx     = bx - ax;
    assign dy     = by - ay;
    assign abs_dx = (dx < 0) ? -dx : dx;
    assign abs_dy = (dy < 0) ? -dy : dy;
    assign steep  = abs_dy > abs_dx;

    // Swap axes for steep lines
    assign sa_maj = steep ? ay : ax;
    assign sa_min = steep ? ax : ay;
    assign sb_maj = steep ? by : bx;
    assign sb_min = steep ? bx : by;

    // Order endpoints so the major coordinate rises
    always_comb begin
        if (sa_maj > sb_maj) begin
            lo_maj = sb_maj;
            lo_min = sb_min;
            hi_maj = sa_maj;
            hi_min = sa_min;
        end else begin
            lo_maj = sa_maj;
            lo_min = sa_min;
            hi_maj = sb_maj;
            hi_min = sb_min;
        end
    end

    assign span     = hi_maj - lo_maj;
    assign dmin     = hi_min - lo_min;
    assign abs_dmin = (dmin < 0) ? -dmin : dmin;

    // Pack the new line state
    always_comb begin
        o_line.swapped    = steep;
        o_line.major_pos  = lo_maj;
        o_line.major_end  = hi_maj;
        o_line.minor_pos  = lo_min;
        o_line.major_span = span[IN_W-1:0];
        o_line.minor_span = abs_dmin[IN_W-1:0];
        o_line.err        = signed'({{(ERR_W-IN_W+1){1'b0}}, span[IN_W-1:1]});
        o_line.minor_down = !(lo_min < hi_min);
        o_line.color      = i_pen_color;
    end

endmodule

`default_nettype wire

FILE: src/blsu_stepper.sv
// Point step: stamp of the current point and the line state after it.
`timescale 1ns / 1ps
`default_nettype none

module blsu_stepper
    import blsu_pkg::*;
(
    input  wire t_line               i_line,
    input  wire logic [SIDE_W-1:0]   i_thickness,
    output t_stamp                   o_stamp,
    output t_line                    o_next
);

    logic        [SIDE_W-1:0]       side;
    logic signed [COORD_W-1:0]      half;
    logic signed [COORD_W-1:0]      px, py;
    logic signed [ERR_W-1:0]        err_sub;
    logic                           last;

    // Clamp the stamp side into its legal range
    always_comb begin
        priority if (i_thickness < SIDE_MIN) begin
            side = SIDE_MIN;
        end else if (i_thickness > SIDE_MAX) begin
            side = SIDE_MAX;
        end else begin
            side = i_thickness;
        end
    end

    assign half = signed'({{(COORD_W-SIDE_W+1){1'b0}}, side[SIDE_W-1:1]});
    assign px   = i_line.swapped ? i_line.minor_pos : i_line.major_pos;
    assign py   = i_line.swapped ? i_line.major_pos : i_line.minor_pos;
    assign last = (i_line.major_pos == i_line.major_end);

    // Form the stamp word
    always_comb begin
        o_stamp.rect_x = px - half;
        o_stamp.rect_y = py - half;
        o_stamp.side   = side;
        o_stamp.color  = i_line.color;
        o_stamp.last   = last;
    end

    assign err_sub = i_line.err - signed'({{(ERR_W-IN_W){1'b0}}, i_line.minor_span});

    // Advance the error term, the minor and the major position
    always_comb begin
        o_next = i_line;
        if (err_sub < 0) begin
            o_next.err = err_sub + signed'({{(ERR_W-IN_W){1'b0}}, i_line.major_span});
            o_next.minor_pos = i_line.minor_down ? i_line.minor_pos - COORD_W'(1)
                                                 : i_line.minor_pos + COORD_W'(1);
        end else begin
            o_next.err = err_sub;
        end
        if (!last) begin
            o_next.major_pos = i_line.major_pos + COORD_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: src/blsu_checker.sv
// Port-level checker of the line stamper and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module blsu_checker
    import blsu_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      o_cfg_ready,
    input  wire logic [SIDE_W-1:0]         i_cfg_data,
    input  wire logic                      i_valid,
    input  wire logic                      o_ready,
    input  wire logic                      i_func,
    input  wire logic signed [IN_W-1:0]    i_start_x,
    input  wire logic signed [IN_W-1:0]    i_start_y,
    input  wire logic signed [IN_W-1:0]    i_end_x,
    input  wire logic signed [IN_W-1:0]    i_end_y,
    input  wire logic [COLOR_W-1:0]        i_pen_color,
    input  wire logic                      o_valid,
    input  wire logic                      i_ready,
    input  wire logic signed [COORD_W-1:0] o_rect_x,
    input  wire logic signed [COORD_W-1:0] o_rect_y,
    input  wire logic [SIDE_W-1:0]         o_rect_side,
    input  wire logic [COLOR_W-1:0]        o_stamp_color,
    input  wire logic                      o_is_last
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rect_x) && $stable(o_rect_y)
            && $stable(o_rect_side) && $stable(o_stamp_color) && $stable(o_is_last)))
        else $error("result word changed while stalled");

    // Stamp side stays clamped
    a_side_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rect_side >= SIDE_MIN && o_rect_side <= SIDE_MAX))
        else $error("stamp side out of range");

    // A start word never produces a result
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_func == FUNC_START) && (!o_valid || i_ready))
            |=> !o_valid)
        else $error("start word produced a result");

    // Result side is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Input is refused only while a result is stalled
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input refused without a stalled result");

endmodule

bind bresenham_line_stamper_unit blsu_checker u_blsu_checker (.*);

`default_nettype wire

FILE: dv/bresenham_line_stamper_unit_tb.sv
// Testbench of the line stamper: directed table then random lines, checked against a predictor.
`timescale 1ns / 1ps

module bresenham_line_stamper_unit_tb;
    import blsu_pkg::*;

    localparam int PLAN_N       = 25;
    localparam int RANDOM_WORDS = 1250;
    localparam int QUIET        = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 400000;

    // One word on the input side
    typedef struct packed {
        t_func                     func;
        logic signed [IN_W-1:0]    sx;
        logic signed [IN_W-1:0]    sy;
        logic signed [IN_W-1:0]    ex;
        logic signed [IN_W-1:0]    ey;
        logic        [COLOR_W-1:0] color;
    } t_line_cmd;

    // One row of the directed table
    typedef struct packed {
        logic              set_side;
        logic [SIDE_W-1:0] side;
        t_line_cmd         cmd;
        logic              typed;
        t_stamp            want;
    } t_plan_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic [SIDE_W-1:0]         cfg_data = '0;
    logic                      cfg_ready;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      in_func = 1'b0;
    logic signed [IN_W-1:0]    in_sx = '0;
    logic signed [IN_W-1:0]    in_sy = '0;
    logic signed [IN_W-1:0]    in_ex = '0;
    logic signed [IN_W-1:0]    in_ey = '0;
    logic [COLOR_W-1:0]        in_color = '0;

    logic                      res_valid;
    logic                      out_ready = 1'b0;
    logic signed [COORD_W-1:0] res_x;
    logic signed [COORD_W-1:0] res_y;
    logic [SIDE_W-1:0]         res_side;
    logic [COLOR_W-1:0]        res_color;
    logic                      res_last;

    // Predictor state
    t_line             line_st = '0;
    logic              line_busy = 1'b0;
    logic [SIDE_W-1:0] thickness_reg = SIDE_RESET;

    t_stamp    stamps_due[$];
    int        fault_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        words_sent = 0;
    int        phase_left = 0;
    bit        hold_req = 1'b0;
    t_plan_row plan[PLAN_N];

    bresenham_line_stamper_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_func        (in_func),
        .i_start_x     (in_sx),
        .i_start_y     (in_sy),
        .i_end_x       (in_ex),
        .i_end_y       (in_ey),
        .i_pen_color   (in_color),
        .o_valid       (res_valid),
        .i_ready       (out_ready),
        .o_rect_x      (res_x),
        .o_rect_y      (res_y),
        .o_rect_side   (res_side),
        .o_stamp_color (res_color),
        .o_is_last     (res_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d stamps outstanding", $time, stamps_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int fit_coord(input int v);
        if (v < -16384) return -16384;
        if (v > 16383) return 16383;
        return v;
    endfunction

    // Load a line on start, or produce the next stamp while a line is live
    function automatic void advance_line(input t_line_cmd c, output bit got,
                                         output t_stamp st);
        int ax, ay, bx, by, tmp, side, half, px, py, e, mp;
        bit steep, last;
        got = 1'b0;
        st  = '0;
        if (c.func == FUNC_START) begin
            ax = c.sx;
            ay = c.sy;
            bx = c.ex;
            by = c.ey;
            steep = mag(by - ay) > mag(bx - ax);
            if (steep) begin
                tmp = ax; ax = ay; ay = tmp;
                tmp = bx; bx = by; by = tmp;
            end
            // order the endpoints so the major coordinate rises
            if (ax > bx) begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            line_st.swapped    = steep;
            line_st.major_pos  = COORD_W'(ax);
            line_st.major_end  = COORD_W'(bx);
            line_st.minor_pos  = COORD_W'(ay);
            line_st.major_span = IN_W'(bx - ax);
            line_st.minor_span = IN_W'(mag(by - ay));
            line_st.err        = ERR_W'((bx - ax) / 2);
            line_st.minor_down = !(ay < by);
            line_st.color      = c.color;
            line_busy          = 1'b1;
            return;
        end
        if (!line_busy) return;

        // clamp the side into the legal stamp range
        side = thickness_reg;
        if (side < 1) side = 1;
        if (side > 64) side = 64;
        half = side / 2;
        last = (line_st.major_pos == line_st.major_end);
        if (line_st.swapped) begin
            px = line_st.minor_pos;
            py = line_st.major_pos;
        end else begin
            px = line_st.major_pos;
            py = line_st.minor_pos;
        end
        st.rect_x = COORD_W'(px - half);
        st.rect_y = COORD_W'(py - half);
        st.side   = SIDE_W'(side);
        st.color  = line_st.color;
        st.last   = last;
        got       = 1'b1;

        // advance the error term and the minor axis
        e = line_st.err;
        e -= int'(line_st.minor_span);
        if (e < 0) begin
            mp = line_st.minor_pos;
            mp += line_st.minor_down ? -1 : 1;
            line_st.minor_pos = COORD_W'(mp);
            e += int'(line_st.major_span);
        end
        line_st.err = ERR_W'(e);
        if (last) line_busy = 1'b0;
        else line_st.major_pos = line_st.major_pos + COORD_W'(1);
    endfunction

    function automatic t_plan_row plan_row(input bit set_side, input int side, input t_func f,
                                           input int sx, input int sy, input int ex,
                                           input int ey, input int color, input bit typed,
                                           input int wx, input int wy, input int wside,
                                           input int wlast);
        t_plan_row r;
        r.set_side    = set_side;
        r.side        = SIDE_W'(side);
        r.cmd.func    = f;
        r.cmd.sx      = IN_W'(sx);
        r.cmd.sy      = IN_W'(sy);
        r.cmd.ex      = IN_W'(ex);
        r.cmd.ey      = IN_W'(ey);
        r.cmd.color   = COLOR_W'(color);
        r.typed       = typed;
        r.want.rect_x = COORD_W'(wx);
        r.want.rect_y = COORD_W'(wy);
        r.want.side   = SIDE_W'(wside);
        r.want.color  = COLOR_W'(color);
        r.want.last   = wlast[0];
        return r;
    endfunction

    function automatic t_line_cmd random_cmd(input t_func f);
        t_line_cmd c;
        c.func  = f;
        c.sx    = IN_W'($urandom);
        c.sy    = IN_W'($urandom);
        c.ex    = IN_W'($urandom);
        c.ey    = IN_W'($urandom);
        c.color = COLOR_W'($urandom);
        return c;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Offer one word in bursts with random gaps; return at the accepting edge
    task automatic send_word(input t_line_cmd c);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_func  <= c.func;
        in_sx    <= c.sx;
        in_sy    <= c.sy;
        in_ex    <= c.ex;
        in_ey    <= c.ey;
        in_color <= c.color;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Send and predict one random-part word; count it unless it is a step with no stamp
    task automatic issue(input t_line_cmd c);
        bit     got;
        t_stamp st;
        send_word(c);
        advance_line(c, got, st);
        if (got) stamps_due.push_back(st);
        if (!(c.func == FUNC_STEP && !got)) begin
            words_sent++;
            phase_left--;
        end
    endtask

    // Hold the input, let every stamp drain, then wait out the pipeline
    task automatic drain_stamps();
        @(negedge clk);
        in_valid <= 1'b0;
        while (stamps_due.size() != 0) @(negedge clk);
        repeat (QUIET) @(negedge clk);
    endtask

    task automatic write_thickness(input logic [SIDE_W-1:0] v);
        drain_stamps();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        thickness_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Check each stamp word against the oldest expectation
    always @(posedge clk) begin
        t_stamp want;
        if (rst_n && res_valid && out_ready) begin
            if (stamps_due.size() == 0) begin
                $display("%0t: stamp word at (%0d, %0d) arrived with none expected",
                         $time, res_x, res_y);
                fault_count++;
            end else begin
                want = stamps_due.pop_front();
                compare_field("rect_x", want.rect_x, res_x);
                compare_field("rect_y", want.rect_y, res_y);
                compare_field("rect_side", want.side, res_side);
                compare_field("stamp_color", want.color, res_color);
                compare_field("is_last", want.last, res_last);
            end
        end
    end

    // Result side: stretches of differing stall rates, plus long hold-offs on request
    initial begin : result_sink
        int stretch;
        int stall_pct;
        forever begin
            stretch = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
            repeat (stretch) begin
                @(negedge clk);
                if (hold_req) begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_req = 1'b0;
                end
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin : main_seq
        bit        got;
        bit        second_hold;
        t_stamp    st;
        t_line_cmd c;
        int        k, kind, reach, sx, sy, ex, ey, points;

        second_hold = 1'b0;

        // directed table: typed step rows carry the latched colour in their colour column
        plan[0]  = plan_row(0, 0,   FUNC_STEP,  -1, -1, -1, -1, 'hFFFF, 0, 0, 0, 0, 0);
        plan[1]  = plan_row(0, 0,   FUNC_START,  0,  0,  0,  0, 'hFFFF, 0, 0, 0, 0, 0);
        plan[2]  = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'hFFFF, 1, 0, 0, 1, 1);
        plan[3]  = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[4]  = plan_row(0, 0,   FUNC_START, -16384, -16384, 16383, 16383, 'h0000,
                            0, 0, 0, 0, 0);
        plan[5]  = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000,
                            1, -16384, -16384, 1, 0);
        plan[6]  = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[7]  = plan_row(0, 0,   FUNC_START, 16383, -16384, -16384, 16383, 'h5AA5,
                            0, 0, 0, 0, 0);
        plan[8]  = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h5AA5,
                            1, -16384, 16383, 1, 0);
        plan[9]  = plan_row(1, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[10] = plan_row(1, 127, FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[11] = plan_row(0, 0,   FUNC_START,  5, -3,  2,  9, 'h1234, 0, 0, 0, 0, 0);
        plan[12] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[13] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[14] = plan_row(1, 64,  FUNC_START, 16383, 16383, 16383, 16383, 'h8001,
                            0, 0, 0, 0, 0);
        plan[15] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h8001,
                            1, 16351, 16351, 64, 1);
        plan[16] = plan_row(1, 65,  FUNC_START, -16384, 0, -16384, 0, 'h7FFE,
                            0, 0, 0, 0, 0);
        plan[17] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h7FFE,
                            1, -16416, -32, 64, 1);
        plan[18] = plan_row(1, 2,   FUNC_START,  2,  1, -2,  0, 'h00FF, 0, 0, 0, 0, 0);
        plan[19] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[20] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[21] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[22] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[23] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);
        plan[24] = plan_row(0, 0,   FUNC_STEP,   0,  0,  0,  0, 'h0000, 0, 0, 0, 0, 0);

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        for (k = 0; k < PLAN_N; k++) begin
            if (plan[k].set_side) write_thickness(plan[k].side);
            send_word(plan[k].cmd);
            advance_line(plan[k].cmd, got, st);
            if (got) stamps_due.push_back(plan[k].typed ? plan[k].want : st);
        end

        // random lines, mostly well formed, with long result hold-offs at the start and halfway
        hold_req   = 1'b1;
        phase_left = $urandom_range(100, 200);
        while (words_sent < RANDOM_WORDS) begin
            if (phase_left <= 0) begin
                case ($urandom_range(0, 7))
                    0: write_thickness(SIDE_W'(0));
                    1: write_thickness(SIDE_MIN);
                    2: write_thickness(SIDE_MAX);
                    3: write_thickness(SIDE_W'(65));
                    4: write_thickness(SIDE_W'(127));
                    default: write_thickness(SIDE_W'($urandom_range(0, 127)));
                endcase
                phase_left = $urandom_range(100, 200);
            end
            if (!second_hold && words_sent >= RANDOM_WORDS / 2) begin
                hold_req    = 1'b1;
                second_hold = 1'b1;
            end

            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                // short line anywhere in the plane, stepped to its end or cut short
                reach = ($urandom_range(0, 9) == 0) ? 40 : 8;
                sx = int'($urandom_range(0, 32767)) - 16384;
                sy = int'($urandom_range(0, 32767)) - 16384;
                ex = fit_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
                ey = fit_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
                c = random_cmd(FUNC_START);
                c.sx = IN_W'(sx);
                c.sy = IN_W'(sy);
                c.ex = IN_W'(ex);
                c.ey = IN_W'(ey);
                issue(c);
                points = ((mag(ex - sx) > mag(ey - sy)) ? mag(ex - sx) : mag(ey - sy)) + 1;
                if ($urandom_range(0, 6) == 0) points = $urandom_range(0, points);
                repeat (points) issue(random_cmd(FUNC_STEP));
                if ($urandom_range(0, 4) == 0) issue(random_cmd(FUNC_STEP));
            end else if (kind < 88) begin
                // long line with random endpoints, abandoned after a few points
                issue(random_cmd(FUNC_START));
                repeat ($urandom_range(1, 16)) issue(random_cmd(FUNC_STEP));
            end else begin
                repeat ($urandom_range(1, 3)) issue(random_cmd(FUNC_STEP));
            end
        end

        // drain and settle
        drain_stamps();
        repeat (QUIET) @(negedge clk);
        if (fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
